// ----- design/sorted_key_value_table_unit_defines.svh -----
// Assertion helpers used by the checker file design/skvt_checker.sv
`ifndef SORTED_KEY_VALUE_TABLE_UNIT_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, checked on rising clk outside reset
`define SKVT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on rising clk outside reset
`define SKVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/skvt_pkg.sv -----
package skvt_pkg;

  // Table size and counter width (count register is at least 5 bits wide)
  localparam int CAPACITY = 16;
  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam int CNT_W    = (CNT_BITS > 5) ? CNT_BITS : 5;

  typedef logic signed [31:0] word_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef struct packed {
    op_t   op;
    word_t key;
    word_t value;
  } in_item_t;

  typedef struct packed {
    status_t    status;
    word_t      found_value;
    logic [4:0] entry_count;
  } out_item_t;

  // Contents of one cell
  typedef struct packed {
    logic  valid;
    word_t key;
    word_t value;
  } slot_t;

  // Compare flags of one cell against the incoming key
  typedef struct packed {
    logic less;
    logic eq;
  } cell_stat_t;

endpackage

// ----- design/skvt_cell.sv -----
module skvt_cell import skvt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       upd,
  input  in_item_t   item,
  input  slot_t      prev_slot,
  input  logic       prev_less,
  output slot_t      slot,
  output cell_stat_t stat
);

  logic  valid_r, valid_nxt;
  word_t key_r, key_nxt;
  word_t value_r, value_nxt;

  assign slot = '{valid: valid_r, key: key_r, value: value_r};

  // Compare stored key with the broadcast key
  assign stat.less = valid_r && (key_r < item.key);
  assign stat.eq   = valid_r && (key_r == item.key);

  // Keep if smaller, take the new pair at the boundary, else shift from the left
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    if (upd) begin
      priority if (stat.less) begin
        valid_nxt = valid_r;
      end else if (prev_less) begin
        valid_nxt = 1'b1;
        key_nxt   = item.key;
        value_nxt = item.value;
      end else begin
        valid_nxt = prev_slot.valid;
        key_nxt   = prev_slot.key;
        value_nxt = prev_slot.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
  end

endmodule

// ----- design/skvt_match.sv -----
module skvt_match import skvt_pkg::*; (
  input  slot_t      slots [CAPACITY],
  input  cell_stat_t stats [CAPACITY],
  output logic       hit,
  output word_t      hit_value
);

  // Keys are unique, so at most one cell matches: OR the masked values
  always_comb begin
    hit       = 1'b0;
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit       = hit | stats[i].eq;
      hit_value = hit_value | (stats[i].eq ? slots[i].value : '0);
    end
  end

endmodule

// ----- design/sorted_key_value_table_unit.sv -----
// A result is registered at the edge that accepts the transaction.
// Throughput: one transaction per cycle while no held result stalls the input;
// every cell compares and shifts in the accepting cycle, the row match in that path.
// Reset (synchronous, active low) clears all cell valid bits, the pair count and
// the output valid flag; stored keys and values and the result data are not cleared.
module sorted_key_value_table_unit import skvt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  slot_t      slots [CAPACITY];
  cell_stat_t stats [CAPACITY];
  logic       hit;
  word_t      hit_value;
  logic       accept;
  logic       full;
  logic       upd;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  // Output register frees as soon as its result is taken
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign full = (count_r == CNT_W'(CAPACITY));
  assign upd  = accept && (in_data.op == OP_INSERT) && !hit && !full;

  // Row of compare-and-shift cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    slot_t prev_slot;
    logic  prev_less;
    if (i == 0) begin : g_head
      assign prev_slot = '0;
      assign prev_less = 1'b1;
    end else begin : g_link
      assign prev_slot = slots[i-1];
      assign prev_less = stats[i-1].less;
    end
    skvt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .upd       (upd),
      .item      (in_data),
      .prev_slot (prev_slot),
      .prev_less (prev_less),
      .slot      (slots[i]),
      .stat      (stats[i])
    );
  end

  skvt_match u_match (
    .slots     (slots),
    .stats     (stats),
    .hit       (hit),
    .hit_value (hit_value)
  );

  // Result and count update
  always_comb begin
    count_nxt     = upd ? count_r + CNT_W'(1) : count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (accept) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.found_value = '0;
      out_data_nxt.entry_count = count_nxt[4:0];
      if (in_data.op == OP_LOOKUP) begin
        out_data_nxt.status = hit ? ST_FOUND : ST_NOT_FOUND;
        if (hit) begin
          out_data_nxt.found_value = hit_value;
        end
      end else begin
        priority if (hit) begin
          out_data_nxt.status = ST_DUPLICATE;
        end else if (full) begin
          out_data_nxt.status = ST_FULL;
        end else begin
          out_data_nxt.status = ST_INSERTED;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule

// ----- design/skvt_checker.sv -----
`include "sorted_key_value_table_unit_defines.svh"

module skvt_checker import skvt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Held result stays until taken
  `SKVT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result dropped or changed while stalled")

  // Input only backs up behind a pending result
  `SKVT_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled with no pending result")

  // Value field is zero unless a lookup hit
  `SKVT_ASSERT_NOW(a_value_zero, out_valid && (out_data.status != ST_FOUND), out_data.found_value == '0, "nonzero value without a hit")

  // Accepted transaction always yields a result next cycle
  `SKVT_ASSERT_NEXT(a_result, in_valid && !in_stall, out_valid, "accepted transaction produced no result")

endmodule

bind sorted_key_value_table_unit skvt_checker u_skvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- test/sorted_key_value_table_checker.sv -----
`timescale 1ns / 100ps
// Watches both channels, tracks the sorted table and checks every result
module sorted_key_value_table_checker import skvt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending_count
);

  localparam int MAX_SHOWN = 100;

  // Shadow copy of the table, slots 0 .. pair_total-1 in ascending key order
  word_t     shadow_key [CAPACITY];
  word_t     shadow_val [CAPACITY];
  int        pair_total;
  out_item_t awaited_results[$];
  out_item_t oldest;
  int        shown;

  // Apply one transaction to the shadow table and return its result
  function automatic out_item_t lookup_or_insert(input in_item_t item);
    out_item_t res;
    word_t     k;
    int        pos;
    logic      hit;
    k = item.key;
    pos = 0;
    while (pos < pair_total && shadow_key[pos] < k) pos++;
    hit = (pos < pair_total) && (shadow_key[pos] == k);
    res.found_value = '0;
    if (item.op == OP_LOOKUP) begin
      res.status = hit ? ST_FOUND : ST_NOT_FOUND;
      if (hit) res.found_value = shadow_val[pos];
    end else if (hit) begin
      // duplicate wins over full
      res.status = ST_DUPLICATE;
    end else if (pair_total >= CAPACITY) begin
      res.status = ST_FULL;
    end else begin
      for (int i = pair_total; i > pos; i--) begin
        shadow_key[i] = shadow_key[i - 1];
        shadow_val[i] = shadow_val[i - 1];
      end
      shadow_key[pos] = k;
      shadow_val[pos] = item.value;
      pair_total++;
      res.status = ST_INSERTED;
    end
    res.entry_count = 5'(pair_total);
    return res;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    fail_count++;
    if (shown < MAX_SHOWN) begin
      shown++;
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endtask

  // Results are checked before the transaction accepted at the same edge is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      pair_total = 0;
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (shown < MAX_SHOWN) begin
            shown++;
            $display("%0t ns: unexpected result, expected none, actual %h", $time, out_data);
          end
        end else begin
          oldest = awaited_results.pop_front();
          if (out_data.status !== oldest.status)
            report_mismatch("status", 32'(oldest.status), 32'(out_data.status));
          if (out_data.found_value !== oldest.found_value)
            report_mismatch("found_value", oldest.found_value, out_data.found_value);
          if (out_data.entry_count !== oldest.entry_count)
            report_mismatch("entry_count", 32'(oldest.entry_count),
                            32'(out_data.entry_count));
        end
      end
      if (in_valid && !in_stall) awaited_results.push_back(lookup_or_insert(in_data));
    end
    pending_count = awaited_results.size();
  end

endmodule

// ----- test/tb_sorted_key_value_table_unit.sv -----
`timescale 1ns / 100ps
module tb_sorted_key_value_table_unit;
  import skvt_pkg::*;

  localparam int    RANDOM_ITEMS = 1500;
  localparam int    QUIET_LIMIT  = 1000;
  localparam int    LONG_HOLD    = 80;
  localparam word_t KEY_MIN      = 32'h8000_0000;
  localparam word_t KEY_MAX      = 32'h7FFF_FFFF;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fail_count;
  int        pending_count;

  bit        sender_idle;
  word_t     table_keys[$];

  sorted_key_value_table_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  sorted_key_value_table_checker CHECK (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly random words, sometimes an extreme
  function automatic word_t rand_word();
    case ($urandom_range(0, 19))
      0:       return KEY_MIN;
      1:       return KEY_MAX;
      2:       return '0;
      3:       return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  // Offer one transaction after an optional gap, hold it until accepted
  task automatic offer(input op_t op_sel, input word_t key_in, input word_t val_in);
    int gap;
    gap = sender_idle ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{op: op_sel, key: key_in, value: val_in};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Result side: random stall per result, no-stall stretches, one long hold-off
  initial begin : result_sink
    int hold;
    int taken;
    bit idle_mode;
    hold = 0;
    taken = 0;
    idle_mode = 1'b1;
    forever begin
      out_stall <= (hold > 0);
      if (hold > 0) hold--;
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        taken++;
        if (taken % 150 == 0) idle_mode = ($urandom_range(0, 2) != 0);
        if (taken == 200) hold = LONG_HOLD;
        else hold = idle_mode ? $urandom_range(0, 12) : 0;
      end
    end
  end

  // Ends the run when no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    bit [3:0] fill_nibble[10];
    word_t    known;
    word_t    fresh;
    int       dice;
    fill_nibble = '{4'h5, 4'hC, 4'h2, 4'h6, 4'h9, 4'h1, 4'hD, 4'h3, 4'hB, 4'h4};
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    sender_idle = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty lookup, extremes, front/middle/end inserts, duplicate
    offer(OP_LOOKUP, '0, '0);
    offer(OP_INSERT, '0, KEY_MAX);
    offer(OP_INSERT, KEY_MAX, KEY_MIN);
    offer(OP_INSERT, KEY_MIN, '0);
    offer(OP_INSERT, '1, '1);
    offer(OP_INSERT, 32'sd1, 32'h5555_5555);
    offer(OP_INSERT, KEY_MAX, 32'sd1);
    offer(OP_LOOKUP, KEY_MIN, '1);
    offer(OP_LOOKUP, KEY_MAX, '0);
    offer(OP_LOOKUP, '1, 32'sd7);
    offer(OP_LOOKUP, 32'sd2, '0);
    offer(OP_LOOKUP, KEY_MIN + 1, '0);
    offer(OP_INSERT, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    table_keys = '{'0, KEY_MAX, KEY_MIN, '1, 32'sd1, 32'hAAAA_AAAA};

    // Fill to capacity with distinct keys in mixed order
    foreach (fill_nibble[i]) begin
      fresh = {fill_nibble[i], 28'($urandom)};
      table_keys.push_back(fresh);
      offer(OP_INSERT, fresh, rand_word());
    end

    // Full table: new key rejected, duplicate reported as duplicate
    offer(OP_INSERT, 32'sd2, 32'sd9);
    offer(OP_INSERT, KEY_MIN, 32'sd3);
    offer(OP_LOOKUP, table_keys[10], '0);

    // Random: mostly hits and near misses on stored keys, plus rejected inserts
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) sender_idle = ($urandom_range(0, 2) != 0);
      if (n == 700) begin
        in_valid <= 1'b0;
        drain_results();
      end
      known = table_keys[$urandom_range(0, table_keys.size() - 1)];
      dice = $urandom_range(0, 99);
      if (dice < 35) offer(OP_LOOKUP, known, rand_word());
      else if (dice < 50) offer(OP_LOOKUP, $urandom_range(0, 1) ? known + 1 : known - 1,
                                rand_word());
      else if (dice < 60) offer(OP_LOOKUP, rand_word(), rand_word());
      else if (dice < 75) offer(OP_INSERT, known, rand_word());
      else offer(OP_INSERT, rand_word(), rand_word());
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/skvt_pkg.sv
design/skvt_cell.sv
design/skvt_match.sv
design/sorted_key_value_table_unit.sv
design/skvt_checker.sv
test/sorted_key_value_table_checker.sv
test/tb_sorted_key_value_table_unit.sv
